// File: design/clut_pkg.sv
// ----------------------------------------------------------------------------
// clut_pkg
// Shared constants, ramp tables and helper functions of the colormap table
// entry generator.
// ----------------------------------------------------------------------------
package clut_pkg;

    // Q0.16 positions; 1.0 needs the 17th bit
    localparam int ONE_Q16 = 65536;
    localparam int Q_W     = 17;

    // ramp storage
    localparam int RAMP_SLOTS = 8;
    localparam int SLOT_W     = $clog2(RAMP_SLOTS);
    localparam int MAX_STOPS  = 8;
    localparam int CNT_W      = $clog2(RAMP_SLOTS + 1);

    // table index to position: t = round(idx * ONE / TABLE_LAST)
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_LAST    = TABLE_ENTRIES - 1;
    localparam int T_STEP        = ONE_Q16 / TABLE_LAST;
    localparam int T_REM         = ONE_Q16 % TABLE_LAST;
    localparam int T_HALF        = TABLE_LAST / 2;

    // shared divider: 16 quotient bits, 17-bit divisor
    localparam int DIV_Q_W = 16;
    localparam int DIV_D_W = 17;
    localparam int DIV_N_W = DIV_D_W + DIV_Q_W;

    // floor(x / 1000) for x < 2^26 as (x * RECIP_1000) >> RECIP_SHIFT
    localparam int          RECIP_SHIFT = 36;
    localparam logic [26:0] RECIP_1000  = 27'd68719477;
    localparam logic [25:0] ROUND_1000  = 26'd500;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // stop positions in thousandths, base stop at -1000
    localparam logic signed [10:0] STOP_POS [4][RAMP_SLOTS] = '{
        '{-11'sd1000, 11'sd0, 11'sd256, 11'sd512, 11'sd767, 11'sd1000, 11'sd0, 11'sd0},
        '{-11'sd1000, 11'sd0, 11'sd186, 11'sd360, 11'sd512, 11'sd674, 11'sd826,
          11'sd1000},
        '{-11'sd1000, 11'sd0, 11'sd227, 11'sd455, 11'sd705, 11'sd1000, 11'sd0, 11'sd0},
        '{-11'sd1000, 11'sd0, 11'sd209, 11'sd419, 11'sd628, 11'sd826, 11'sd1000, 11'sd0}
    };

    localparam logic [23:0] STOP_RGB [4][RAMP_SLOTS] = '{
        '{24'h1e0a2e, 24'h440154, 24'h375ea3, 24'h16a097, 24'h5fd552, 24'hfdee18,
          24'h000000, 24'h000000},
        '{24'h1a0e2e, 24'h30123b, 24'h4467f4, 24'h1bc7d4, 24'h28ec8b, 24'h9bfb4d,
          24'hfdab32, 24'hd23105},
        '{24'h23263a, 24'h3a2f6e, 24'h7d2bc4, 24'he01d74, 24'hff7a14, 24'hffe61f,
          24'h000000, 24'h000000},
        '{24'h111111, 24'h00004a, 24'h0000ff, 24'h00ffff, 24'hffff00, 24'hff0000,
          24'hffffff, 24'h000000}
    };

    localparam logic [CNT_W-1:0] RAMP_LEN [4] = '{
        CNT_W'(6), CNT_W'(8), CNT_W'(6), CNT_W'(7)
    };

    // usable stop count of a ramp: capped by MAX_STOPS, at least two
    function automatic logic [CNT_W-1:0] ramp_count(input logic [1:0] scheme);
        logic [CNT_W-1:0] n;
        n = RAMP_LEN[scheme];
        if (n > CNT_W'(MAX_STOPS)) begin
            n = CNT_W'(MAX_STOPS);
        end
        if (n < CNT_W'(2)) begin
            n = CNT_W'(2);
        end
        return n;
    endfunction

    // rounded position of a table index, Q0.16
    function automatic logic [Q_W-1:0] t_of_index(input logic [7:0] idx);
        logic [Q_W-1:0] base;
        logic [9:0]     rnd;
        base = Q_W'(idx) * Q_W'(T_STEP);
        rnd  = 10'(idx) * 10'(T_REM) + 10'(T_HALF);
        return base + ((rnd >= 10'(TABLE_LAST)) ? Q_W'(1) : Q_W'(0));
    endfunction

endpackage

// File: design/clut_div.sv
// ----------------------------------------------------------------------------
// clut_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clut_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [clut_pkg::DIV_N_W-1:0]  i_dividend,
    input  logic [clut_pkg::DIV_D_W-1:0]  i_divisor,
    output clut_pkg::t_div_status         o_status,
    output logic [clut_pkg::DIV_Q_W-1:0]  o_quotient
);

    // dividend must be below divisor << DIV_Q_W
    logic                                r_busy;
    logic                                r_done;
    logic [$clog2(clut_pkg::DIV_Q_W)-1:0] r_cnt;
    logic [clut_pkg::DIV_D_W-1:0]        r_rem;
    logic [clut_pkg::DIV_D_W-1:0]        r_div;
    logic [clut_pkg::DIV_Q_W-1:0]        r_low;
    logic [clut_pkg::DIV_Q_W-1:0]        r_quo;

    logic [clut_pkg::DIV_D_W:0]          trial;
    logic [clut_pkg::DIV_D_W:0]          diff;
    logic                                ge;
    logic [clut_pkg::DIV_D_W-1:0]        n_rem;

    always_comb begin
        trial = {r_rem, r_low[clut_pkg::DIV_Q_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[clut_pkg::DIV_D_W-1:0] : trial[clut_pkg::DIV_D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_rem  <= i_dividend[clut_pkg::DIV_N_W-1:clut_pkg::DIV_Q_W];
                r_low  <= i_dividend[clut_pkg::DIV_Q_W-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= {r_low[clut_pkg::DIV_Q_W-2:0], 1'b0};
                r_quo <= {r_quo[clut_pkg::DIV_Q_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

// File: design/colormap_lut_entry_generator.sv
// ----------------------------------------------------------------------------
// colormap_lut_entry_generator
// RGB color of one entry of a spectrum colormap table, interpolated between
// the stops of a fixed ramp whose lower part is bent around a noise knee.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ------------------------
//  cfg       in         i_cfg_we                   i_cfg_index, i_cfg_data
//  request   in         i_in_valid / o_in_stall    i_index
//  result    out        o_out_valid / i_out_stall  o_red, o_green, o_blue
//
//  Requests: one at a time. The time from accept to result grows with the
//  stops walked (2..8) and is shorter when the fraction saturates or the
//  stop pair is empty, since no fraction division is then needed. The stop
//  walk (multiplier passes for each stop) and the divider set this time.
//  The knee is cached; the first request after a floor or ceiling write
//  waits for its division unless the knee clamps to 0 or 1.
//  Reset: synchronous, active low; config returns to viridis, -110/-20 dBm.
//  The result register frees the core, so a stalled result only holds the
//  next request at its last step.
// ----------------------------------------------------------------------------
module colormap_lut_entry_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam int QW = clut_pkg::Q_W;
    localparam int SW = clut_pkg::SLOT_W;

    localparam logic signed [12:0] NOISE_LEVEL = -13'sd1440;
    localparam logic signed [11:0] FLOOR_RESET = -12'sd1760;
    localparam logic signed [11:0] CEIL_RESET  = -12'sd320;
    localparam logic [QW-1:0]      Q_ONE       = QW'(clut_pkg::ONE_Q16);
    localparam logic signed [18:0] POS_ONE     = 19'sd65536;

    typedef enum logic [1:0] {
        REG_SCHEME = 2'd0,
        REG_FLOOR  = 2'd1,
        REG_CEIL   = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KNEE,
        S_POS_MUL,
        S_POS_SCALE,
        S_POS_CMP,
        S_F_DIV,
        S_MIX_R,
        S_MIX_G,
        S_MIX_B,
        S_MIX_END
    } t_state;

    // rounded channel blend: (a*2^16 + (b-a)*f + 2^15) >> 16
    function automatic logic [7:0] mix_channel(input logic [7:0] a,
                                               input logic signed [55:0] prod);
        logic signed [26:0] sum;
        sum = $signed({3'b000, a, 16'h0000}) + $signed(prod[26:0]) + 27'sd32768;
        return sum[23:16];
    endfunction

    // ---------------- registers ----------------
    t_state                   r_state;
    logic [1:0]               r_scheme;
    logic signed [11:0]       r_floor;
    logic signed [11:0]       r_ceil;
    logic                     r_knee_ok;
    logic [QW-1:0]            r_knee;
    logic [QW-1:0]            r_t;
    logic [QW-1:0]            r_lo;
    logic [QW-1:0]            r_f;
    logic [SW-1:0]            r_sidx;
    logic signed [55:0]       r_prod;
    logic [7:0]               r_ch_red;
    logic [7:0]               r_ch_green;
    logic                     r_out_valid;
    logic [7:0]               r_out_red;
    logic [7:0]               r_out_green;
    logic [7:0]               r_out_blue;

    // ---------------- combinational ----------------
    logic                     accept;
    logic signed [12:0]       num;
    logic signed [12:0]       span;
    logic signed [12:0]       num_a;
    logic signed [12:0]       span_a;
    logic                     knee_zero;
    logic                     knee_full;

    logic [SW-1:0]            midx;
    logic signed [10:0]       p_mul;
    logic signed [10:0]       p_cur;
    logic [9:0]               p_mag;
    logic [QW-1:0]            p_factor;
    logic [25:0]              scale_in;
    logic [QW-1:0]            q_pos;
    logic signed [18:0]       pos_raw;
    logic [QW-1:0]            pos;
    logic [clut_pkg::CNT_W-1:0] count;
    logic                     last_stop;
    logic                     found;
    logic signed [17:0]       d_t;
    logic signed [17:0]       w_pair;
    logic                     f_divide;

    logic [23:0]              rgb_a;
    logic [23:0]              rgb_b;
    logic [7:0]               mul_ch_a;
    logic [7:0]               mul_ch_b;
    logic [7:0]               res_ch_a;
    logic [7:0]               mix_out;

    logic signed [27:0]       mul_a;
    logic signed [27:0]       mul_b;
    logic signed [55:0]       product;

    logic                          div_start;
    logic [clut_pkg::DIV_N_W-1:0]  div_dividend;
    logic [clut_pkg::DIV_D_W-1:0]  div_divisor;
    clut_pkg::t_div_status         div_stat;
    logic [clut_pkg::DIV_Q_W-1:0]  div_quo;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // knee = (noise - floor) / (ceiling - floor), sign folded into the span
    always_comb begin
        num       = NOISE_LEVEL - $signed({r_floor[11], r_floor});
        span      = $signed({r_ceil[11], r_ceil}) - $signed({r_floor[11], r_floor});
        num_a     = (span < 13'sd0) ? -num : num;
        span_a    = (span < 13'sd0) ? -span : span;
        knee_zero = (span == 13'sd0) || (num_a <= 13'sd0);
        knee_full = (num_a >= span_a);
    end

    // stop position: knee +/- floor((|p| * factor + 500) / 1000), clamped
    always_comb begin
        midx     = (r_state == S_POS_CMP) ? r_sidx + SW'(1) : r_sidx;
        p_mul    = clut_pkg::STOP_POS[r_scheme][midx];
        p_cur    = clut_pkg::STOP_POS[r_scheme][r_sidx];
        p_mag    = (p_mul < 11'sd0) ? 10'(-p_mul) : 10'(p_mul);
        p_factor = (p_mul < 11'sd0) ? r_knee : (Q_ONE - r_knee);
        scale_in = r_prod[25:0] + clut_pkg::ROUND_1000;
        q_pos    = r_prod[clut_pkg::RECIP_SHIFT +: QW];
        if (p_cur < 11'sd0) begin
            pos_raw = $signed({2'b00, r_knee}) - $signed({2'b00, q_pos});
        end else begin
            pos_raw = $signed({2'b00, r_knee}) + $signed({2'b00, q_pos});
        end
        if (pos_raw < 19'sd0) begin
            pos = '0;
        end else if (pos_raw > POS_ONE) begin
            pos = Q_ONE;
        end else begin
            pos = pos_raw[QW-1:0];
        end
    end

    // bracketing pair search and fraction setup
    always_comb begin
        count     = clut_pkg::ramp_count(r_scheme);
        last_stop = (clut_pkg::CNT_W'(r_sidx) == count - clut_pkg::CNT_W'(1));
        found     = (r_sidx != '0) && ((pos >= r_t) || last_stop);
        d_t       = $signed({1'b0, r_t}) - $signed({1'b0, r_lo});
        w_pair    = $signed({1'b0, pos}) - $signed({1'b0, r_lo});
        f_divide  = (w_pair > 18'sd0) && (d_t >= 18'sd0) && (d_t < w_pair);
    end

    // channel selection for the blend passes
    always_comb begin
        rgb_a    = clut_pkg::STOP_RGB[r_scheme][r_sidx - SW'(1)];
        rgb_b    = clut_pkg::STOP_RGB[r_scheme][r_sidx];
        mul_ch_a = rgb_a[7:0];
        mul_ch_b = rgb_b[7:0];
        res_ch_a = rgb_a[7:0];
        case (r_state)
            S_MIX_R: begin
                mul_ch_a = rgb_a[23:16];
                mul_ch_b = rgb_b[23:16];
            end
            S_MIX_G: begin
                mul_ch_a = rgb_a[15:8];
                mul_ch_b = rgb_b[15:8];
                res_ch_a = rgb_a[23:16];
            end
            S_MIX_B: begin
                res_ch_a = rgb_a[15:8];
            end
            default: begin
            end
        endcase
        mix_out = mix_channel(res_ch_a, r_prod);
    end

    // the one multiplier, shared by stop scaling and channel blending
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_POS_MUL, S_POS_CMP: begin
                mul_a = $signed({18'd0, p_mag});
                mul_b = $signed({11'd0, p_factor});
            end
            S_POS_SCALE: begin
                mul_a = $signed({2'b00, scale_in});
                mul_b = $signed({1'b0, clut_pkg::RECIP_1000});
            end
            S_MIX_R, S_MIX_G, S_MIX_B: begin
                mul_a = 28'($signed({1'b0, mul_ch_b}) - $signed({1'b0, mul_ch_a}));
                mul_b = $signed({11'd0, r_f});
            end
            default: begin
            end
        endcase
        product = mul_a * mul_b;
    end

    // divider requests: knee on a cold cache, fraction inside a pair
    always_comb begin
        if (r_state == S_IDLE) begin
            div_start    = accept && !r_knee_ok && !knee_zero && !knee_full;
            div_dividend = clut_pkg::DIV_N_W'({num_a[11:0], 16'h0000})
                         + clut_pkg::DIV_N_W'(span_a[11:1]);
            div_divisor  = clut_pkg::DIV_D_W'(span_a[11:0]);
        end else begin
            div_start    = (r_state == S_POS_CMP) && found && f_divide;
            div_dividend = clut_pkg::DIV_N_W'({d_t[15:0], 16'h0000})
                         + clut_pkg::DIV_N_W'(w_pair[16:1]);
            div_divisor  = w_pair[16:0];
        end
    end

    clut_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_stat),
        .o_quotient (div_quo)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scheme    <= 2'd0;
            r_floor     <= FLOOR_RESET;
            r_ceil      <= CEIL_RESET;
            r_knee_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_SCHEME: r_scheme <= i_cfg_data[1:0];
                    REG_FLOOR: begin
                        r_floor   <= $signed(i_cfg_data);
                        r_knee_ok <= 1'b0;
                    end
                    REG_CEIL: begin
                        r_ceil    <= $signed(i_cfg_data);
                        r_knee_ok <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_t    <= clut_pkg::t_of_index(i_index);
                        r_sidx <= '0;
                        if (r_knee_ok) begin
                            r_state <= S_POS_MUL;
                        end else if (knee_zero) begin
                            r_knee    <= '0;
                            r_knee_ok <= 1'b1;
                            r_state   <= S_POS_MUL;
                        end else if (knee_full) begin
                            r_knee    <= Q_ONE;
                            r_knee_ok <= 1'b1;
                            r_state   <= S_POS_MUL;
                        end else begin
                            r_state <= S_KNEE;
                        end
                    end
                end
                S_KNEE: begin
                    if (div_stat.done) begin
                        r_knee    <= {1'b0, div_quo};
                        r_knee_ok <= 1'b1;
                        r_state   <= S_POS_MUL;
                    end
                end
                S_POS_MUL: begin
                    r_prod  <= product;
                    r_state <= S_POS_SCALE;
                end
                S_POS_SCALE: begin
                    r_prod  <= product;
                    r_state <= S_POS_CMP;
                end
                S_POS_CMP: begin
                    // next stop's first pass overlaps this compare
                    r_prod <= product;
                    if (found) begin
                        if (f_divide) begin
                            r_state <= S_F_DIV;
                        end else begin
                            // empty pair or t below it: 0; past the pair: 1
                            r_f     <= (w_pair > 18'sd0 && d_t >= 18'sd0) ? Q_ONE : '0;
                            r_state <= S_MIX_R;
                        end
                    end else begin
                        r_lo    <= pos;
                        r_sidx  <= r_sidx + SW'(1);
                        r_state <= S_POS_SCALE;
                    end
                end
                S_F_DIV: begin
                    if (div_stat.done) begin
                        r_f     <= {1'b0, div_quo};
                        r_state <= S_MIX_R;
                    end
                end
                S_MIX_R: begin
                    r_prod  <= product;
                    r_state <= S_MIX_G;
                end
                S_MIX_G: begin
                    r_ch_red <= mix_out;
                    r_prod   <= product;
                    r_state  <= S_MIX_B;
                end
                S_MIX_B: begin
                    r_ch_green <= mix_out;
                    r_prod     <= product;
                    r_state    <= S_MIX_END;
                end
                S_MIX_END: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_red   <= r_ch_red;
                        r_out_green <= r_ch_green;
                        r_out_blue  <= mix_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request core not busy after accept");

    a_div_not_reused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_knee_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KNEE && div_stat.done && !i_cfg_we) |=> r_knee_ok)
        else $error("knee result not cached");

    a_knee_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_knee_ok |-> (r_knee <= Q_ONE))
        else $error("knee above 1.0");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX_R) |-> (r_f <= Q_ONE))
        else $error("fraction above 1.0");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for colormap_lut_entry_generator: drives table indexes
// under several ramp and level settings, predicts each RGB entry in the bench
// and compares every returned color, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

    // ------------------------------------------------------------------------
    // Register map and codes
    // ------------------------------------------------------------------------
    localparam logic [1:0] REG_SCHEME  = 2'd0;
    localparam logic [1:0] REG_FLOOR   = 2'd1;
    localparam logic [1:0] REG_CEILING = 2'd2;
    localparam logic [1:0] REG_SPARE   = 2'd3;   // not mapped, writes are dropped

    localparam logic [1:0] SCHEME_VIRIDIS = 2'd0;
    localparam logic [1:0] SCHEME_TURBO   = 2'd1;
    localparam logic [1:0] SCHEME_INFERNO = 2'd2;
    localparam logic [1:0] SCHEME_SPECTRO = 2'd3;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int     CLK_HALF      = 6;
    localparam int     RESET_CYCLES  = 12;
    localparam int     STALL_LIMIT   = 3000;  // cycles with no transfer at all
    localparam int     LONG_HOLD     = 300;   // receiver hold-off in pressure test
    localparam int     SETTLE_CYCLES = 8;     // quiet cycles before a reg write
    localparam int     TAIL_CYCLES   = 60;    // quiet cycles at the end of the run
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 145;

    // color math, Q0.16 positions
    localparam longint UNIT        = 65536;
    localparam longint NOISE_LEVEL = -1440;   // -90 dBm in 1/16 dB
    localparam longint TABLE_LAST  = 255;
    localparam int     STOP_SLOTS  = 8;
    localparam int     STOP_LIMIT  = 8;

    // ramp stops: position in thousandths (base stop at -1000) and color
    localparam int RAMP_STOPS [4] = '{6, 8, 6, 7};

    localparam int RAMP_POS [4][STOP_SLOTS] = '{
        '{-1000, 0, 256, 512, 767, 1000, 0, 0},
        '{-1000, 0, 186, 360, 512, 674, 826, 1000},
        '{-1000, 0, 227, 455, 705, 1000, 0, 0},
        '{-1000, 0, 209, 419, 628, 826, 1000, 0}
    };

    localparam logic [23:0] RAMP_RGB [4][STOP_SLOTS] = '{
        '{24'h1e0a2e, 24'h440154, 24'h375ea3, 24'h16a097, 24'h5fd552, 24'hfdee18,
          24'h000000, 24'h000000},
        '{24'h1a0e2e, 24'h30123b, 24'h4467f4, 24'h1bc7d4, 24'h28ec8b, 24'h9bfb4d,
          24'hfdab32, 24'hd23105},
        '{24'h23263a, 24'h3a2f6e, 24'h7d2bc4, 24'he01d74, 24'hff7a14, 24'hffe61f,
          24'h000000, 24'h000000},
        '{24'h111111, 24'h00004a, 24'h0000ff, 24'h00ffff, 24'hffff00, 24'hff0000,
          24'hffffff, 24'h000000}
    };

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    colormap_lut_entry_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // shadow copy of the register file, as the block should see it
    logic [1:0]         cfg_scheme;
    logic signed [11:0] cfg_floor;
    logic signed [11:0] cfg_ceiling;

    t_color pending_colors [$];   // predicted entries, oldest first

    int  fail_count;
    int  requests_sent;
    int  colors_checked;
    int  reg_writes;
    int  idle_cycles;
    bit  src_idle_en;             // sender inserts random gaps
    bit  sink_idle_en;            // receiver inserts random stall bursts
    int  hold_req;                // bumped by a test to ask for a long hold-off

    t_color seen_head;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_unit(input longint v);
        if (v < 0) begin
            return 0;
        end
        if (v > UNIT) begin
            return UNIT;
        end
        return v;
    endfunction

    // one channel: a + (b - a) * f, rounded half up
    function automatic logic [7:0] blend_channel(input longint a, input longint b,
                                                 input longint f);
        longint v;
        v = a * UNIT + (b - a) * f + 32768;
        if (v < 0) begin
            v = 0;
        end
        return v[23:16];
    endfunction

    function automatic t_color predict_color(input logic [7:0] idx);
        longint      num;
        longint      span;
        longint      knee;
        longint      t;
        longint      p;
        longint      w;
        longint      frac;
        longint      at [STOP_SLOTS];
        int          n_stops;
        int          k;
        int          hi;
        logic [23:0] ca;
        logic [23:0] cb;
        t_color      c;

        n_stops = RAMP_STOPS[cfg_scheme];
        if (n_stops > STOP_LIMIT) begin
            n_stops = STOP_LIMIT;
        end
        if (n_stops < 2) begin
            n_stops = 2;
        end

        // knee: where the noise floor sits on the floor..ceiling axis
        num  = NOISE_LEVEL - longint'(cfg_floor);
        span = longint'(cfg_ceiling) - longint'(cfg_floor);
        if (span == 0) begin
            knee = 0;
        end else begin
            if (span < 0) begin
                span = -span;
                num  = -num;
            end
            if (num <= 0) begin
                knee = 0;
            end else if (num >= span) begin
                knee = UNIT;
            end else begin
                knee = (num * UNIT + span / 2) / span;
            end
        end

        // bend the ramp: base stop squeezed into [0,knee], rest into [knee,1]
        for (k = 0; k < STOP_SLOTS; k++) begin
            at[k] = 0;
        end
        for (k = 0; k < n_stops; k++) begin
            p = RAMP_POS[cfg_scheme][k];
            if (p >= 0) begin
                at[k] = clamp_unit(knee + (p * (UNIT - knee) + 500) / 1000);
            end else begin
                at[k] = clamp_unit(knee - ((-p) * knee + 500) / 1000);
            end
        end

        if (longint'(idx) >= TABLE_LAST) begin
            t = UNIT;
        end else begin
            t = (longint'(idx) * UNIT + TABLE_LAST / 2) / TABLE_LAST;
        end

        // bracketing pair; past the last stop the last pair is kept
        hi = 1;
        while (hi < n_stops - 1 && at[hi] < t) begin
            hi++;
        end
        w = at[hi] - at[hi - 1];
        if (w > 0) begin
            frac = clamp_unit(((t - at[hi - 1]) * UNIT + w / 2) / w);
        end else begin
            frac = 0;
        end

        ca = RAMP_RGB[cfg_scheme][hi - 1];
        cb = RAMP_RGB[cfg_scheme][hi];
        c.index = idx;
        c.red   = blend_channel(longint'(ca[23:16]), longint'(cb[23:16]), frac);
        c.green = blend_channel(longint'(ca[15:8]),  longint'(cb[15:8]),  frac);
        c.blue  = blend_channel(longint'(ca[7:0]),   longint'(cb[7:0]),   frac);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request.
    // The hold-off length is counted here so the sender can keep pushing.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int burst_left;
        int hold_seen;

        hold_left   = 0;
        burst_left  = 0;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                i_out_stall <= 1'b1;
                burst_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted color against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            colors_checked++;
            if (pending_colors.size() == 0) begin
                $error("color %0d/%0d/%0d returned with no request outstanding",
                       o_red, o_green, o_blue);
                fail_count++;
            end else begin
                seen_head = pending_colors.pop_front();
                if (o_red !== seen_head.red) begin
                    $error("red mismatch (index %0d): expected %0d, got %0d",
                           seen_head.index, seen_head.red, o_red);
                    fail_count++;
                end
                if (o_green !== seen_head.green) begin
                    $error("green mismatch (index %0d): expected %0d, got %0d",
                           seen_head.index, seen_head.green, o_green);
                    fail_count++;
                end
                if (o_blue !== seen_head.blue) begin
                    $error("blue mismatch (index %0d): expected %0d, got %0d",
                           seen_head.index, seen_head.blue, o_blue);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a transfer on either channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d colors outstanding",
                     idle_cycles, pending_colors.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one request and hold it until taken. Valid stays high on return,
    // so back-to-back requests never drop it; a gap or a drain lowers it.
    task automatic send_index(input logic [7:0] idx);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_index    <= idx;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        pending_colors = {pending_colors, predict_color(idx)};
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted color came back.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Single-cycle register write; only called with the block idle.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCHEME:  cfg_scheme  = data[1:0];
            REG_FLOOR:   cfg_floor   = data;
            REG_CEILING: cfg_ceiling = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_levels(input int floor_db16, input int ceiling_db16);
        write_reg(REG_FLOOR, 12'(floor_db16));
        write_reg(REG_CEILING, 12'(ceiling_db16));
    endtask

    function automatic logic [7:0] random_index();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0: return 8'd0;
                1: return 8'd1;
                2: return 8'd127;
                3: return 8'd128;
                4: return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random setting; mostly levels that put the knee strictly inside.
    task automatic pick_random_setting();
        int fl;
        int cl;
        write_reg(REG_SCHEME, 12'($urandom_range(0, 3)));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                fl = -2048 + int'($urandom_range(0, 607));
                cl = -1439 + int'($urandom_range(0, 2462));
            end
            5, 6: begin
                // any 12-bit pattern, negative spans and values past 1023 too
                fl = int'($urandom_range(0, 4095));
                cl = int'($urandom_range(0, 4095));
            end
            7: begin
                fl = -2048 + int'($urandom_range(0, 3071));
                cl = fl;
            end
            8: begin
                fl = -2048;
                cl = ($urandom_range(0, 1) == 0) ? 1023 : 2047;
            end
            default: begin
                // both levels on one side of the noise floor
                fl = -1439 + int'($urandom_range(0, 1000));
                cl = -1439 + int'($urandom_range(0, 2462));
            end
        endcase
        set_levels(fl, cl);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset config: viridis, -110 / -20 dBm. Covers both ends of the index.
    task automatic test_reset_config();
        send_index(8'd0);
        send_index(8'd1);
        send_index(8'd128);
        send_index(8'd255);
        wait_results_done();
    endtask

    task automatic test_every_scheme();
        logic [1:0] s;
        for (int k = 0; k < 4; k++) begin
            s = 2'(k);
            write_reg(REG_SCHEME, {10'd0, s});
            send_index(8'd64);
            send_index(8'd170);
            send_index(8'd254);
            wait_results_done();
        end
    endtask

    task automatic test_level_corners();
        write_reg(REG_SCHEME, {10'd0, SCHEME_SPECTRO});

        // zero span: knee forced to 0, base and first stop coincide
        set_levels(-1000, -1000);
        send_index(8'd0);
        send_index(8'd200);
        wait_results_done();

        // noise floor above the ceiling: knee clamps to 1, upper stops
        // all land on 1.0 so the pair has no width
        write_reg(REG_SCHEME, {10'd0, SCHEME_TURBO});
        set_levels(-2048, -1500);
        send_index(8'd100);
        send_index(8'd255);
        wait_results_done();

        // noise floor under the floor: knee clamps to 0; ceiling at the
        // top 12-bit code
        write_reg(REG_SCHEME, {10'd0, SCHEME_INFERNO});
        set_levels(-1000, 2047);
        send_index(8'd50);
        send_index(8'd255);
        wait_results_done();

        // floor above ceiling: both terms flip sign
        write_reg(REG_SCHEME, {10'd0, SCHEME_VIRIDIS});
        set_levels(1023, -2048);
        send_index(8'd30);
        send_index(8'd220);
        wait_results_done();

        // unmapped register index must change nothing
        write_reg(REG_SPARE, 12'($urandom_range(0, 4095)));
        send_index(8'd90);
        wait_results_done();
    endtask

    // Receiver holds off for a long stretch while requests keep coming,
    // so the result register fills and the input side has to stall.
    task automatic test_output_backpressure();
        wait_results_done();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(REG_SCHEME, {10'd0, SCHEME_TURBO});
        set_levels(-1760, -320);
        hold_req++;
        for (int k = 0; k < 20; k++) begin
            send_index(random_index());
        end
        wait_results_done();
    endtask

    // Sender stops until every color is back, then resumes.
    task automatic test_sender_pause();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (int k = 0; k < 10; k++) begin
            send_index(random_index());
        end
        wait_results_done();
        for (int k = 0; k < 10; k++) begin
            send_index(random_index());
        end
        wait_results_done();
    endtask

    // Random indexes over a series of random settings. One middle phase and
    // the closing phases run with no idling at all.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_done();
            pick_random_setting();
            src_idle_en  = (phase < RANDOM_PHASES - 2) && (phase != 2) &&
                           ($urandom_range(0, 3) != 0);
            sink_idle_en = (phase < RANDOM_PHASES - 2) && (phase != 2) &&
                           ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_index(random_index());
            end
        end
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_SCHEME;
        i_cfg_data     = 12'd0;
        i_in_valid     = 1'b0;
        i_index        = 8'd0;
        fail_count     = 0;
        requests_sent  = 0;
        colors_checked = 0;
        reg_writes     = 0;
        idle_cycles    = 0;
        hold_req       = 0;
        src_idle_en    = 1'b0;
        sink_idle_en   = 1'b0;
        // reset values of the register file
        cfg_scheme     = SCHEME_VIRIDIS;
        cfg_floor      = -12'sd1760;
        cfg_ceiling    = -12'sd320;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_every_scheme();
        test_level_corners();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_colors.size() != 0) begin
            $error("%0d predicted colors never returned", pending_colors.size());
            fail_count++;
        end

        $display("Run covered %0d requests and %0d colors over %0d register writes:",
                 requests_sent, colors_checked, reg_writes);
        $display("  all four ramps, zero and inverted spans, clamped knees, back-pressure.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d check(s) failed", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/clut_pkg.sv
design/clut_div.sv
design/colormap_lut_entry_generator.sv
tb/tb.sv
